/* hdl/dmac_pkg.sv */
// dmac_pkg: shared types and constants of the multichannel dma controller
// no dependencies; used by dmac_queue and multichannel_dma_controller
package dmac_pkg;

  // bus item commands
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // completion and status codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNSUPP   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_CHOP     = 2'd3;

  // register map (low address byte)
  localparam logic [7:0] OFF_CONTROL   = 8'hF0;
  localparam logic [7:0] OFF_INTERRUPT = 8'hF4;
  localparam logic [3:0] SEL_ADDR      = 4'h0;
  localparam logic [3:0] SEL_BLOCK     = 4'h4;
  localparam logic [3:0] SEL_CHCTRL    = 4'h8;

  localparam logic [31:0] CONTROL_RESET = 32'h0765_4321;

  // channel control bits
  localparam int CC_DIR   = 0;
  localparam int CC_STEP  = 1;
  localparam int CC_CHOP  = 8;
  localparam int CC_START = 24;
  localparam int CC_TRIG  = 28;

  typedef logic [2:0] chan_t;

  localparam chan_t CH_GPU = 3'd2;
  localparam chan_t CH_OTC = 3'd6;

  // ordering table clear masks
  localparam logic [23:0] OTC_ADDR_MASK = 24'h1F_FFFC;
  localparam logic [23:0] OTC_LINK_MASK = 24'h1F_FFFF;
  localparam logic [23:0] OTC_LINK_END  = 24'hFF_FFFF;
  localparam logic [16:0] WORDS_FULL    = 17'h1_0000;

  typedef struct packed {
    logic  push;
    logic  pop;
    chan_t ch;
  } queue_ctl_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    chan_t head;
  } queue_status_t;

endpackage

/* hdl/multichannel_dma_controller.sv */
// multichannel_dma_controller: register file, request queue and transfer engine
// depends on dmac_pkg, dmac_queue (and through it dmac_ram)
//
//   channel | handshake          | word contents
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_stall  | cmd, reg_offset, write_data
//   out     | out_valid/out_stall| read_data, mem_*_valid, mem_address, mem_word,
//           |                    | busy_res, done_res, done_channel, error_code
//
// one word per cycle sustained while out_stall is low; a word is taken into the
// input register and its result then loads the result register; the state update
// and result logic between the two registers is a single pass
// rst is synchronous and resets valid flags, the register file, queue pointers and transfer state
// out_stall holds the result register and backs up into in_stall once the
// input register is full; in_valid does not depend on in_stall
module multichannel_dma_controller #(
  parameter int NUM_CHANNELS = 7,
  parameter int QUEUE_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        mem_write_valid,
  output logic        mem_read_valid,
  output logic [23:0] mem_address,
  output logic [31:0] mem_word,
  output logic        busy_res,
  output logic        done_res,
  output logic [2:0]  done_channel,
  output logic [1:0]  error_code
);

  localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [7:0]  s1_off;
  logic [31:0] s1_data;
  logic        fire;

  // architectural state
  logic [31:0] control_reg;
  logic [31:0] interrupt_reg;
  logic [31:0] base_address    [NUM_CHANNELS];
  logic [31:0] block_control   [NUM_CHANNELS];
  logic [31:0] channel_control [NUM_CHANNELS];
  logic        transfer_active;
  logic [23:0] current_address;
  logic [16:0] words_left;

  // next state
  logic [31:0] control_next;
  logic [31:0] interrupt_next;
  logic        transfer_active_next;
  logic [23:0] current_address_next;
  logic [16:0] words_left_next;
  logic        base_we;
  logic        block_we;
  logic        cc_we;
  logic [31:0] cc_val;
  logic        do_move;

  // queue
  dmac_pkg::queue_ctl_t    q_ctl;
  dmac_pkg::queue_ctl_t    q_ctl_fire;
  dmac_pkg::queue_status_t q_stat;

  // decode and selected channel
  logic            hit_ctrl;
  logic            hit_irq;
  logic            hit_ch;
  dmac_pkg::chan_t sel_ch;
  logic [CIW-1:0]  sel_idx;
  logic [31:0]     base_cur;
  logic [31:0]     block_cur;
  logic [31:0]     cc_cur;
  logic [31:0]     cc_after;
  logic [30:0]     irq_low;
  logic            irq_flag;
  logic [4:0]      en_bit;
  logic [1:0]      xfer_sync;
  logic            start_ok;

  // shared word mover
  logic [23:0]     mv_addr;
  logic [16:0]     mv_words;
  logic [23:0]     addr_dec;
  logic [23:0]     addr_inc;
  logic [16:0]     words_dec;

  // result of this pass
  logic [31:0]     r_read_data;
  logic            r_mem_wr;
  logic            r_mem_rd;
  logic [23:0]     r_mem_addr;
  logic [31:0]     r_mem_word;
  logic            r_done;
  logic [1:0]      r_err;

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_cmd  <= cmd;
      s1_off  <= reg_offset;
      s1_data <= write_data;
    end
  end

  // address decode: control and interrupt win over the channel map
  assign hit_ctrl = (s1_off == dmac_pkg::OFF_CONTROL);
  assign hit_irq  = (s1_off == dmac_pkg::OFF_INTERRUPT);
  assign hit_ch   = s1_off[7] && !hit_ctrl && !hit_irq &&
                    ({1'b0, s1_off[6:4]} < 4'(NUM_CHANNELS));

  // one channel slot is touched per word: the queue head on a tick, else the addressed one
  assign sel_ch    = (dmac_pkg::cmd_t'(s1_cmd) == dmac_pkg::CMD_TICK) ? q_stat.head
                                                                      : s1_off[6:4];
  assign sel_idx   = sel_ch[CIW-1:0];
  assign base_cur  = base_address[sel_idx];
  assign block_cur = block_control[sel_idx];
  assign cc_cur    = channel_control[sel_idx];

  assign cc_after  = (s1_off[3:0] == dmac_pkg::SEL_CHCTRL) ? s1_data : cc_cur;

  // interrupt write: bit 31 is the summary flag
  assign irq_low  = s1_data[30:0];
  assign irq_flag = irq_low[15] || (irq_low[23] && (|irq_low[22:16]) && (|irq_low[30:24]));

  // enable bit of a channel sits at 4*ch+3
  assign en_bit    = {q_stat.head, 2'b11};
  assign xfer_sync = cc_cur[10:9];
  assign start_ok  = ((q_stat.head == dmac_pkg::CH_GPU) && !xfer_sync[1] &&
                      cc_cur[dmac_pkg::CC_DIR]) ||
                     ((q_stat.head == dmac_pkg::CH_OTC) && (xfer_sync == 2'd0) &&
                      !cc_cur[dmac_pkg::CC_DIR]);

  // a starting transfer loads from the channel registers, a running one from state
  assign mv_addr   = transfer_active ? current_address : base_cur[23:0];
  assign mv_words  = transfer_active ? words_left :
                     ((block_cur[15:0] == 16'd0) ? dmac_pkg::WORDS_FULL
                                                 : {1'b0, block_cur[15:0]});
  assign addr_dec  = mv_addr - 24'd4;
  assign addr_inc  = mv_addr + 24'd4;
  assign words_dec = mv_words - 17'd1;

  always_comb begin
    control_next         = control_reg;
    interrupt_next       = interrupt_reg;
    transfer_active_next = transfer_active;
    current_address_next = current_address;
    words_left_next      = words_left;
    base_we              = 1'b0;
    block_we             = 1'b0;
    cc_we                = 1'b0;
    cc_val               = cc_cur;
    do_move              = 1'b0;
    q_ctl.push           = 1'b0;
    q_ctl.pop            = 1'b0;
    q_ctl.ch             = s1_off[6:4];
    r_read_data          = '0;
    r_mem_wr             = 1'b0;
    r_mem_rd             = 1'b0;
    r_mem_addr           = '0;
    r_mem_word           = '0;
    r_done               = 1'b0;
    r_err                = dmac_pkg::ERR_NONE;

    case (dmac_pkg::cmd_t'(s1_cmd))
      dmac_pkg::CMD_READ: begin
        if (hit_ctrl) begin
          r_read_data = control_reg;
        end else if (hit_irq) begin
          r_read_data = interrupt_reg;
        end else if (hit_ch) begin
          case (s1_off[3:0])
            dmac_pkg::SEL_ADDR:   r_read_data = base_cur;
            dmac_pkg::SEL_BLOCK:  r_read_data = block_cur;
            dmac_pkg::SEL_CHCTRL: r_read_data = cc_cur;
            default:              r_read_data = '0;
          endcase
        end
      end

      dmac_pkg::CMD_WRITE: begin
        if (hit_ctrl) begin
          control_next = s1_data;
        end else if (hit_irq) begin
          interrupt_next = {irq_flag, irq_low};
        end else if (hit_ch && (s1_off[3:0] inside {dmac_pkg::SEL_ADDR, dmac_pkg::SEL_BLOCK,
                                                   dmac_pkg::SEL_CHCTRL})) begin
          base_we  = (s1_off[3:0] == dmac_pkg::SEL_ADDR);
          block_we = (s1_off[3:0] == dmac_pkg::SEL_BLOCK);
          cc_we    = (s1_off[3:0] == dmac_pkg::SEL_CHCTRL);
          cc_val   = s1_data;
          // ready channel: start bit plus sync mode or manual trigger
          if (cc_after[dmac_pkg::CC_START] &&
              ((|cc_after[10:9]) || cc_after[dmac_pkg::CC_TRIG])) begin
            if (q_stat.full) begin
              r_err = dmac_pkg::ERR_OVERFLOW;
            end else begin
              q_ctl.push = 1'b1;
            end
          end
        end
      end

      dmac_pkg::CMD_TICK: begin
        if (q_stat.empty) begin
          transfer_active_next = 1'b0;
        end else if (transfer_active || control_reg[en_bit]) begin
          do_move = transfer_active;
          if (!transfer_active) begin
            // start attempt: the trigger bit is consumed
            cc_we  = 1'b1;
            cc_val = cc_cur & ~(32'd1 << dmac_pkg::CC_TRIG);
            if (cc_cur[dmac_pkg::CC_CHOP]) begin
              r_done = 1'b1;
              r_err  = dmac_pkg::ERR_CHOP;
            end else if (!start_ok) begin
              r_done = 1'b1;
              r_err  = dmac_pkg::ERR_UNSUPP;
            end else begin
              do_move = 1'b1;
            end
          end

          if (do_move) begin
            transfer_active_next = 1'b1;
            words_left_next      = words_dec;
            if (q_stat.head == dmac_pkg::CH_OTC) begin
              // ordering table: each entry links to the one below it
              r_mem_wr             = 1'b1;
              r_mem_addr           = mv_addr & dmac_pkg::OTC_ADDR_MASK;
              r_mem_word           = {8'd0, (mv_words == 17'd1) ? dmac_pkg::OTC_LINK_END
                                              : (addr_dec & dmac_pkg::OTC_LINK_MASK)};
              current_address_next = addr_dec;
            end else begin
              r_mem_rd             = 1'b1;
              r_mem_addr           = mv_addr;
              current_address_next = cc_cur[dmac_pkg::CC_STEP] ? addr_dec : addr_inc;
            end
            if (words_dec == 17'd0) begin
              r_done = 1'b1;
            end
          end

          // completion: drop start and trigger, clear enable, retire queue head
          if (r_done) begin
            cc_we                = 1'b1;
            cc_val               = cc_cur & ~((32'd1 << dmac_pkg::CC_START) |
                                              (32'd1 << dmac_pkg::CC_TRIG));
            control_next[en_bit] = 1'b0;
            q_ctl.pop            = 1'b1;
            transfer_active_next = 1'b0;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg     <= dmac_pkg::CONTROL_RESET;
      interrupt_reg   <= '0;
      transfer_active <= 1'b0;
      current_address <= '0;
      words_left      <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        base_address[i]    <= '0;
        block_control[i]   <= '0;
        channel_control[i] <= '0;
      end
    end else if (fire) begin
      control_reg     <= control_next;
      interrupt_reg   <= interrupt_next;
      transfer_active <= transfer_active_next;
      current_address <= current_address_next;
      words_left      <= words_left_next;
      if (base_we) begin
        base_address[sel_idx] <= s1_data;
      end
      if (block_we) begin
        block_control[sel_idx] <= s1_data;
      end
      if (cc_we) begin
        channel_control[sel_idx] <= cc_val;
      end
    end
  end

  // queue only moves on a processed word
  always_comb begin
    q_ctl_fire      = q_ctl;
    q_ctl_fire.push = q_ctl.push && fire;
    q_ctl_fire.pop  = q_ctl.pop && fire;
  end

  dmac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (q_ctl_fire),
    .stat (q_stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data       <= r_read_data;
      mem_write_valid <= r_mem_wr;
      mem_read_valid  <= r_mem_rd;
      mem_address     <= r_mem_addr;
      mem_word        <= r_mem_word;
      busy_res        <= transfer_active_next;
      done_res        <= r_done;
      done_channel    <= r_done ? q_stat.head : 3'd0;
      error_code      <= r_err;
    end
  end

endmodule

/* hdl/dmac_ram.sv */
// dmac_ram: generic single write port ram with registered read
// no dependencies
module dmac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/dmac_queue.sv */
// dmac_queue: channel request fifo, ram backed, head word registered
// depends on dmac_pkg and dmac_ram
module dmac_queue #(
  parameter int DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dmac_pkg::queue_ctl_t   ctl,
  output dmac_pkg::queue_status_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        rd_ptr_next;
  logic [CW-1:0]        count;
  logic                 push_ok;
  logic                 pop_ok;
  logic                 bypass;
  dmac_pkg::chan_t      bypass_ch;
  dmac_pkg::chan_t      ram_q;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign push_ok     = ctl.push && (count != CW'(DEPTH));
  assign pop_ok      = ctl.pop && (count != '0);
  assign rd_ptr_next = pop_ok ? ptr_inc(rd_ptr) : rd_ptr;

  // read address follows the next head so the word is ready after the edge
  dmac_ram #(
    .WIDTH ($bits(dmac_pkg::chan_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_ptr),
    .wdata (ctl.ch),
    .raddr (rd_ptr_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      bypass <= 1'b0;
    end else begin
      rd_ptr <= rd_ptr_next;
      if (push_ok) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
      // write into the slot being read: ram returns old data this once
      bypass <= push_ok && (wr_ptr == rd_ptr_next);
    end
  end

  always_ff @(posedge clk) begin
    bypass_ch <= ctl.ch;
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.head  = bypass ? bypass_ch : ram_q;

endmodule
